// ----- rtl/ktln_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and transaction types for the keyframe triangle blender.
// Depends on nothing; every module of the block imports it.
package ktln_pkg;

	localparam int COORD_BITS  = 21;
	localparam int NORMAL_BITS = 16;
	localparam int LERP_BITS   = 16;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = LERP_BITS + 1 + DIFF_W;
	localparam int CROSS_W = 2 * DIFF_W + 1;
	localparam int TOP_W   = $clog2(CROSS_W);
	localparam int SHIFT_W = CROSS_W + 31;
	localparam int SQRT_STEPS = 32;
	localparam int QUOT_W  = NORMAL_BITS - 1;

	typedef struct packed {
		logic [62:0] first_current;
		logic [62:0] first_next;
		logic [62:0] second_current;
		logic [62:0] second_next;
		logic [62:0] third_current;
		logic [62:0] third_next;
		logic        mesh_last_in;
	} ktln_in_t;

	typedef struct packed {
		logic [62:0] blended_first;
		logic [62:0] blended_second;
		logic [62:0] blended_third;
		logic [47:0] face_normal;
		logic        degenerate;
		logic        mesh_last_out;
	} ktln_out_t;

endpackage

// ----- rtl/keyframe_triangle_lerp_normal.sv -----
`timescale 1ns / 1ps
// Top level: keyframe vertex blend and unit face normal, fully pipelined.
// Depends on ktln_pkg for constants and transaction types.
// One transaction enters every cycle.
// Most of the depth comes from the 32-stage square root and the 15-stage normal divider.
// Reset clears the factor register and all stage valid bits; busy stays low.
module keyframe_triangle_lerp_normal
	import ktln_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	input  ktln_in_t         operands,
	output logic             done,
	output ktln_out_t        result
);

	typedef struct packed {
		logic [62:0] b0;
		logic [62:0] b1;
		logic [62:0] b2;
		logic        last;
	} vtx_t;

	typedef struct packed {
		vtx_t             vtx;
		logic             degen;
		logic [2:0]       neg;
		logic [2:0][30:0] m;
	} nc_t;

	logic [LERP_BITS-1:0] lerp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lerp_q <= '0;
		end else if (cfg_we) begin
			lerp_q <= LERP_BITS'(cfg_wdata);
		end
	end

	assign busy = 1'b0;

	logic [62:0] in_w [6];
	always_comb begin
		in_w[0] = operands.first_current;
		in_w[1] = operands.first_next;
		in_w[2] = operands.second_current;
		in_w[3] = operands.second_next;
		in_w[4] = operands.third_current;
		in_w[5] = operands.third_next;
	end

	logic [9:0] vld_s;

	logic signed [COORD_BITS-1:0] c_s1 [3][3];
	logic signed [DIFF_W-1:0]     d_s1 [3][3];
	logic                         last_s1;
	logic signed [COORD_BITS-1:0] c_s2 [3][3];
	logic signed [PROD_W-1:0]     p_s2 [3][3];
	logic                         last_s2;
	logic signed [COORD_BITS-1:0] v_s3 [3][3];
	vtx_t                         vtx_s3;
	logic signed [DIFF_W-1:0]     a_s4 [3];
	logic signed [DIFF_W-1:0]     b_s4 [3];
	vtx_t                         vtx_s4;
	logic signed [2*DIFF_W-1:0]   x_s5 [6];
	vtx_t                         vtx_s5;
	logic [CROSS_W-1:0]           m_s6 [3];
	logic [2:0]                   neg_s6;
	vtx_t                         vtx_s6;
	logic [CROSS_W-1:0]           m_s7 [3];
	logic [CROSS_W-1:0]           max_s7;
	logic [2:0]                   neg_s7;
	vtx_t                         vtx_s7;
	logic [CROSS_W-1:0]           m_s8 [3];
	logic [TOP_W-1:0]             top_s8;
	logic                         degen_s8;
	logic [2:0]                   neg_s8;
	vtx_t                         vtx_s8;
	nc_t                          nc_s9;
	logic [61:0]                  sq_s10 [3];
	nc_t                          nc_s10;

	logic signed [COORD_BITS-1:0] v_c [3][3];
	logic [62:0]                  pack_c [3];
	logic signed [PROD_W-1:0]     rnd_c;
	logic signed [CROSS_W-1:0]    r_c [3];
	logic [CROSS_W-1:0]           max_c;
	logic [TOP_W-1:0]             top_c;
	logic [SHIFT_W-1:0]           wide_c;
	nc_t                          nc_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pack_c[i] = '0;
			for (int k = 0; k < 3; k++) begin
				rnd_c = p_s2[i][k] + PROD_W'(1 << (LERP_BITS - 1));
				v_c[i][k] = c_s2[i][k] + COORD_BITS'(rnd_c >>> LERP_BITS);
				pack_c[i][(2 - k) * COORD_BITS +: COORD_BITS] = v_c[i][k];
			end
		end
		r_c[0] = CROSS_W'(x_s5[0]) - CROSS_W'(x_s5[1]);
		r_c[1] = CROSS_W'(x_s5[2]) - CROSS_W'(x_s5[3]);
		r_c[2] = CROSS_W'(x_s5[4]) - CROSS_W'(x_s5[5]);
		max_c = m_s6[0];
		if (m_s6[1] > max_c) begin
			max_c = m_s6[1];
		end
		if (m_s6[2] > max_c) begin
			max_c = m_s6[2];
		end
		top_c = '0;
		for (int k = 0; k < CROSS_W; k++) begin
			if (max_s7[k]) begin
				top_c = TOP_W'(k);
			end
		end
		nc_c.vtx = vtx_s8;
		nc_c.degen = degen_s8;
		nc_c.neg = neg_s8;
		for (int k = 0; k < 3; k++) begin
			wide_c = SHIFT_W'(m_s8[k]);
			if (32'(top_s8) > 30) begin
				nc_c.m[k] = 31'(wide_c >> (top_s8 - TOP_W'(30)));
			end else begin
				nc_c.m[k] = 31'(wide_c << (TOP_W'(30) - top_s8));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				c_s1[i][k] <= in_w[2*i][(2 - k) * COORD_BITS +: COORD_BITS];
				d_s1[i][k] <= DIFF_W'($signed(in_w[2*i+1][(2 - k) * COORD_BITS +: COORD_BITS]))
					- DIFF_W'($signed(in_w[2*i][(2 - k) * COORD_BITS +: COORD_BITS]));
				c_s2[i][k] <= c_s1[i][k];
				p_s2[i][k] <= $signed({1'b0, lerp_q}) * d_s1[i][k];
				v_s3[i][k] <= v_c[i][k];
			end
		end
		last_s1 <= operands.mesh_last_in;
		last_s2 <= last_s1;
		vtx_s3 <= '{b0: pack_c[0], b1: pack_c[1], b2: pack_c[2], last: last_s2};

		for (int k = 0; k < 3; k++) begin
			a_s4[k] <= DIFF_W'(v_s3[0][k]) - DIFF_W'(v_s3[1][k]);
			b_s4[k] <= DIFF_W'(v_s3[0][k]) - DIFF_W'(v_s3[2][k]);
		end
		vtx_s4 <= vtx_s3;

		x_s5[0] <= a_s4[1] * b_s4[2];
		x_s5[1] <= b_s4[1] * a_s4[2];
		x_s5[2] <= b_s4[0] * a_s4[2];
		x_s5[3] <= a_s4[0] * b_s4[2];
		x_s5[4] <= a_s4[0] * b_s4[1];
		x_s5[5] <= b_s4[0] * a_s4[1];
		vtx_s5 <= vtx_s4;

		for (int k = 0; k < 3; k++) begin
			neg_s6[k] <= r_c[k][CROSS_W-1];
			m_s6[k] <= r_c[k][CROSS_W-1] ? CROSS_W'(-r_c[k]) : CROSS_W'(r_c[k]);
		end
		vtx_s6 <= vtx_s5;

		m_s7 <= m_s6;
		max_s7 <= max_c;
		neg_s7 <= neg_s6;
		vtx_s7 <= vtx_s6;

		m_s8 <= m_s7;
		top_s8 <= top_c;
		degen_s8 <= (max_s7 == '0);
		neg_s8 <= neg_s7;
		vtx_s8 <= vtx_s7;

		nc_s9 <= nc_c;

		for (int k = 0; k < 3; k++) begin
			sq_s10[k] <= nc_s9.m[k] * nc_s9.m[k];
		end
		nc_s10 <= nc_s9;
	end

	logic [63:0] sqv_s [SQRT_STEPS+1];
	logic [63:0] sqr_s [SQRT_STEPS+1];
	nc_t         sqc_s [SQRT_STEPS+1];
	logic        sqvld_s [SQRT_STEPS+1];

	always_ff @(posedge clk) begin
		sqv_s[0] <= 64'(sq_s10[0]) + 64'(sq_s10[1]) + 64'(sq_s10[2]);
		sqr_s[0] <= '0;
		sqc_s[0] <= nc_s10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			sqvld_s[0] <= 1'b0;
		end else begin
			vld_s <= {vld_s[8:0], start & ~busy};
			sqvld_s[0] <= vld_s[9];
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [63:0] Bit = 64'(1) << (62 - 2 * j);
		logic [63:0] trial;
		assign trial = sqr_s[j] + Bit;
		always_ff @(posedge clk) begin
			if (sqv_s[j] >= trial) begin
				sqv_s[j+1] <= sqv_s[j] - trial;
				sqr_s[j+1] <= (sqr_s[j] >> 1) + Bit;
			end else begin
				sqv_s[j+1] <= sqv_s[j];
				sqr_s[j+1] <= sqr_s[j] >> 1;
			end
			sqc_s[j+1] <= sqc_s[j];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqvld_s[j+1] <= 1'b0;
			end else begin
				sqvld_s[j+1] <= sqvld_s[j];
			end
		end
	end

	logic [2:0][63:0]        dvr_s [QUOT_W+1];
	logic [2:0][QUOT_W-1:0]  dvq_s [QUOT_W+1];
	logic [31:0]             dvl_s [QUOT_W+1];
	nc_t                     dvc_s [QUOT_W+1];
	logic                    dvvld_s [QUOT_W+1];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			dvr_s[0][k] <= (64'(sqc_s[SQRT_STEPS].m[k]) << (NORMAL_BITS - 2))
				+ 64'(sqr_s[SQRT_STEPS][31:1]);
			dvq_s[0][k] <= '0;
		end
		dvl_s[0] <= sqr_s[SQRT_STEPS][31:0];
		dvc_s[0] <= sqc_s[SQRT_STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvvld_s[0] <= 1'b0;
		end else begin
			dvvld_s[0] <= sqvld_s[SQRT_STEPS];
		end
	end

	for (genvar j = 0; j < QUOT_W; j++) begin : g_div
		localparam int Sh = QUOT_W - 1 - j;
		logic [63:0] dsr;
		assign dsr = 64'(dvl_s[j]) << Sh;
		always_ff @(posedge clk) begin
			for (int k = 0; k < 3; k++) begin
				if (dvr_s[j][k] >= dsr) begin
					dvr_s[j+1][k] <= dvr_s[j][k] - dsr;
					dvq_s[j+1][k] <= dvq_s[j][k] | (QUOT_W'(1) << Sh);
				end else begin
					dvr_s[j+1][k] <= dvr_s[j][k];
					dvq_s[j+1][k] <= dvq_s[j][k];
				end
			end
			dvl_s[j+1] <= dvl_s[j];
			dvc_s[j+1] <= dvc_s[j];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvvld_s[j+1] <= 1'b0;
			end else begin
				dvvld_s[j+1] <= dvvld_s[j];
			end
		end
	end

	nc_t                     fin_c;
	logic [47:0]             norm_c;
	logic [NORMAL_BITS-1:0]  comp_c;

	always_comb begin
		fin_c = dvc_s[QUOT_W];
		norm_c = '0;
		for (int k = 0; k < 3; k++) begin
			comp_c = NORMAL_BITS'(dvq_s[QUOT_W][k]);
			if (fin_c.neg[k]) begin
				comp_c = -comp_c;
			end
			norm_c[(2 - k) * NORMAL_BITS +: NORMAL_BITS] = comp_c;
		end
		if (fin_c.degen) begin
			norm_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		result.blended_first <= fin_c.vtx.b0;
		result.blended_second <= fin_c.vtx.b1;
		result.blended_third <= fin_c.vtx.b2;
		result.face_normal <= norm_c;
		result.degenerate <= fin_c.degen;
		result.mesh_last_out <= fin_c.vtx.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvvld_s[QUOT_W];
		end
	end

endmodule
